### src/brb_pkg.sv
// ---------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// request and result layouts, register map, mode and policy codes
// ---------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned LEVEL_W       = 9;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 4;

  // request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // overflow policies, any other code behaves as drop newest
  localparam logic [1:0] POLICY_DROP_OLDEST = 2'd0;
  localparam logic [1:0] POLICY_DROP_NEWEST = 2'd1;
  localparam logic [1:0] POLICY_ERROR       = 2'd2;

  // register byte addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_POLICY    = 4'h0;
  localparam logic [APB_ADDR_W-1:0] ADDR_HIGH_MARK = 4'h4;
  localparam logic [APB_ADDR_W-1:0] ADDR_LOW_MARK  = 4'h8;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] write_byte;
    logic              block_end;
  } brb_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_byte;
    logic               read_valid;
    logic               write_accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic               high_water;
    logic [LEVEL_W-1:0] peak_fill;
    logic [TOTAL_W-1:0] overflow_total;
  } brb_out_t;

  typedef struct packed {
    logic [1:0]         overflow_policy;
    logic [LEVEL_W-1:0] high_mark;
    logic [LEVEL_W-1:0] low_mark;
  } brb_cfg_t;

endpackage

### src/brb_cfg.sv
// ---------------------------------------------------------------------------
// brb_cfg: configuration registers
// apb-style write and readback of policy and water marks
// ---------------------------------------------------------------------------
module brb_cfg
  import brb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output brb_cfg_t              cfg_o
);

  brb_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr)
        ADDR_POLICY:    cfg_d.overflow_policy = pwdata[1:0];
        ADDR_HIGH_MARK: cfg_d.high_mark       = pwdata[LEVEL_W-1:0];
        ADDR_LOW_MARK:  cfg_d.low_mark        = pwdata[LEVEL_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr)
      ADDR_POLICY:    prdata = APB_DATA_W'(cfg_q.overflow_policy);
      ADDR_HIGH_MARK: prdata = APB_DATA_W'(cfg_q.high_mark);
      ADDR_LOW_MARK:  prdata = APB_DATA_W'(cfg_q.low_mark);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/brb_store.sv
// ---------------------------------------------------------------------------
// brb_store: byte storage
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module brb_store
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/byte_ring_buffer_with_overflow_policy.sv
// ---------------------------------------------------------------------------
// byte_ring_buffer_with_overflow_policy: byte fifo with overflow handling
// circular byte store with fill statistics and a high-water flag
// ---------------------------------------------------------------------------
// Each request is a byte write, a byte read, a flush or a spare no-op, and
// gives exactly one result that shows the state after it. One request is
// taken every clock cycle unless in_stall_o holds it; its result goes through
// two register stages (the state and storage read register, then the output
// register), and a stalled result does not stop the next request until both
// stages are full. The rate is set by the single pass through the pointer and
// fill-count update, with one store write port and one registered read port.
// When the fifo is full the overflow policy decides: drop oldest discards the
// oldest byte and keeps the new one, drop newest and error reject it (error
// also leaves the high-water flag untouched). The overflow total counts
// blocks, closed by block_end, in which any byte met a full fifo. A flush
// clears pointers, fill level and the flag but keeps peak and overflow
// statistics. The store needs no clearing after reset; reads only reach
// bytes that were written.
// ---------------------------------------------------------------------------
module byte_ring_buffer_with_overflow_policy
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  brb_in_t               in_req_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output brb_out_t              out_res_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // compare width wide enough for both fill count and water marks
  localparam int unsigned CMP_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  brb_cfg_t cfg;

  brb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // fifo state
  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic [PTR_W-1:0]   rptr_q, rptr_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   peak_q, peak_d;
  logic [TOTAL_W-1:0] ovf_cnt_q, ovf_cnt_d;
  logic               flag_q, flag_d;
  logic               blk_ovf_q, blk_ovf_d;

  // stage a: request done, state registers and read data hold its result
  logic a_valid_q;
  logic a_rvalid_q, a_rvalid_d;
  logic a_acc_q, a_acc_d;
  // stage b: output register
  logic     o_valid_q;
  brb_out_t o_res_q;

  logic a_move;
  logic in_fire;
  logic mem_we;
  logic mem_re;
  logic [DATA_W-1:0] mem_rdata;

  // handshake: stage a drains into the output register when that one frees
  assign a_move     = a_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_move;
  assign in_fire    = in_valid_i && !in_stall_o;

  function automatic logic next_flag(input logic [CNT_W-1:0] fill,
                                     input logic cur,
                                     input logic [LEVEL_W-1:0] hi,
                                     input logic [LEVEL_W-1:0] lo);
    logic f;
    f = cur;
    if (CMP_W'(fill) >= CMP_W'(hi)) f = 1'b1;
    // clearing wins when both marks are met
    if (CMP_W'(fill) <= CMP_W'(lo)) f = 1'b0;
    return f;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // request processing
  always_comb begin
    logic full;
    logic store;
    logic upd;
    logic ovf_now;
    logic [CNT_W-1:0] fill_new;

    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    fill_d     = fill_q;
    peak_d     = peak_q;
    ovf_cnt_d  = ovf_cnt_q;
    flag_d     = flag_q;
    blk_ovf_d  = blk_ovf_q;
    a_rvalid_d = 1'b0;
    a_acc_d    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    ovf_now    = 1'b0;

    full     = (fill_q == CNT_FULL);
    store    = !full || (cfg.overflow_policy == POLICY_DROP_OLDEST);
    upd      = !(full && (cfg.overflow_policy == POLICY_ERROR));
    fill_new = full ? fill_q : fill_q + 1'b1;

    if (in_fire) begin
      case (in_req_i.mode)
        MODE_WRITE: begin
          if (store) begin
            mem_we  = 1'b1;
            wptr_d  = ptr_inc(wptr_q);
            fill_d  = fill_new;
            a_acc_d = 1'b1;
            // drop oldest on a full fifo: the oldest byte is overwritten
            if (full) rptr_d = ptr_inc(rptr_q);
            if (fill_new > peak_q) peak_d = fill_new;
          end
          if (upd) begin
            flag_d = next_flag(store ? fill_new : fill_q, flag_q,
                               cfg.high_mark, cfg.low_mark);
          end
          ovf_now = blk_ovf_q || full;
          if (in_req_i.block_end) begin
            if (ovf_now) ovf_cnt_d = ovf_cnt_q + 1'b1;
            blk_ovf_d = 1'b0;
          end else begin
            blk_ovf_d = ovf_now;
          end
        end
        MODE_READ: begin
          if (fill_q != '0) begin
            mem_re     = 1'b1;
            a_rvalid_d = 1'b1;
            rptr_d     = ptr_inc(rptr_q);
            fill_d     = fill_q - 1'b1;
            flag_d     = next_flag(fill_q - 1'b1, flag_q,
                                   cfg.high_mark, cfg.low_mark);
          end
        end
        MODE_FLUSH: begin
          wptr_d = '0;
          rptr_d = '0;
          fill_d = '0;
          flag_d = 1'b0;
        end
        default: begin
          // unused mode reports the state unchanged
        end
      endcase
    end
  end

  brb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wptr_q),
    .wr_data_i (in_req_i.write_byte),
    .rd_en_i   (mem_re),
    .rd_addr_i (rptr_q),
    .rd_data_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q    <= '0;
      rptr_q    <= '0;
      fill_q    <= '0;
      peak_q    <= '0;
      ovf_cnt_q <= '0;
      flag_q    <= 1'b0;
      blk_ovf_q <= 1'b0;
    end else begin
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
      fill_q    <= fill_d;
      peak_q    <= peak_d;
      ovf_cnt_q <= ovf_cnt_d;
      flag_q    <= flag_d;
      blk_ovf_q <= blk_ovf_d;
    end
  end

  // stage a flags; the state registers only change when stage a reloads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_rvalid_q <= a_rvalid_d;
      a_acc_q    <= a_acc_d;
    end
  end

  // result assembled from the state that the stage a request left behind
  brb_out_t a_res;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] peak_ext;

  assign fill_ext = CMP_W'(fill_q);
  assign peak_ext = CMP_W'(peak_q);

  always_comb begin
    a_res.read_byte      = a_rvalid_q ? mem_rdata : '0;
    a_res.read_valid     = a_rvalid_q;
    a_res.write_accepted = a_acc_q;
    a_res.fill_level     = fill_ext[LEVEL_W-1:0];
    a_res.high_water     = flag_q;
    a_res.peak_fill      = peak_ext[LEVEL_W-1:0];
    a_res.overflow_total = ovf_cnt_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (a_move) begin
      o_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      o_res_q <= a_res;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_res_o   = o_res_q;

endmodule

### tb/tb_byte_ring_buffer_with_overflow_policy.sv
// ---------------------------------------------------------------------------
// tb_byte_ring_buffer_with_overflow_policy: self-checking bench for the fifo
// drives write, read, flush and spare-mode requests under every overflow
// policy, predicts each result from a local fifo model and compares the
// results field by field, with random idling on both channels
// ---------------------------------------------------------------------------
module tb_byte_ring_buffer_with_overflow_policy;
  import brb_pkg::*;

  localparam int unsigned RING_DEPTH  = DEPTH_DEFAULT;
  localparam int unsigned RING_PTR_W  = $clog2(RING_DEPTH);
  // spare codes: mode three is a no-op, policy three acts as drop newest
  localparam logic [1:0]  MODE_NOP     = 2'd3;
  localparam logic [1:0]  POLICY_SPARE = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned REPORT_MAX   = 10;

  // a queued request; hold makes the sender wait until no result is due
  typedef struct {
    brb_in_t req;
    bit      hold;
  } request_slot_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  brb_in_t               in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  brb_out_t              out_res_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  byte_ring_buffer_with_overflow_policy #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // requests waiting to be sent and results waiting to come back
  request_slot_t queued_requests[$];
  brb_out_t      due_results[$];

  // fifo model state and its copy of the registers
  logic [7:0]  ring_bytes [RING_DEPTH];
  int unsigned ring_wr, ring_rd, ring_fill, ring_peak;
  logic [31:0] ring_blocks_lost;
  bit          ring_high, ring_block_hit;
  logic [1:0]  cfg_policy;
  int unsigned cfg_high_mark, cfg_low_mark;

  // bookkeeping
  int unsigned send_idle_pct  = 13;
  int unsigned recv_stall_pct = 48;
  int unsigned requests_taken, results_seen, mismatches, quiet_cycles;
  int unsigned overwrites, rejects, empty_reads, flushes;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // fifo model
  // -------------------------------------------------------------------------
  function automatic void ring_reset();
    ring_wr          = 0;
    ring_rd          = 0;
    ring_fill        = 0;
    ring_peak        = 0;
    ring_blocks_lost = '0;
    ring_high        = 1'b0;
    ring_block_hit   = 1'b0;
    cfg_policy       = POLICY_DROP_OLDEST;
    cfg_high_mark    = 0;
    cfg_low_mark     = 0;
  endfunction

  // hysteresis: set at or above the high mark, clear at or below the low
  // mark, and clearing wins when both hold
  function automatic void refresh_high_water();
    if (ring_fill >= cfg_high_mark) ring_high = 1'b1;
    if (ring_fill <= cfg_low_mark) ring_high = 1'b0;
  endfunction

  // apply one request to the model and return the result it must produce
  function automatic brb_out_t ring_step(input brb_in_t req);
    brb_out_t res;
    bit       hit_full;
    bit       keep_byte;
    bit       touch_flag;
    res        = '0;
    hit_full   = 1'b0;
    keep_byte  = 1'b1;
    touch_flag = 1'b1;
    case (req.mode)
      MODE_WRITE: begin
        hit_full = (ring_fill == RING_DEPTH);
        if (hit_full) begin
          if (cfg_policy == POLICY_DROP_OLDEST) begin
            // oldest byte goes, the new one takes its place
            ring_rd   = (ring_rd + 1) % RING_DEPTH;
            ring_fill = RING_DEPTH - 1;
            overwrites++;
          end else begin
            // drop newest, error and the spare code all reject
            keep_byte = 1'b0;
            rejects++;
            if (cfg_policy == POLICY_ERROR) touch_flag = 1'b0;
          end
        end
        if (keep_byte) begin
          ring_bytes[RING_PTR_W'(ring_wr)] = req.write_byte;
          ring_wr             = (ring_wr + 1) % RING_DEPTH;
          ring_fill++;
          res.write_accepted  = 1'b1;
          if (ring_fill > ring_peak) ring_peak = ring_fill;
        end
        if (touch_flag) refresh_high_water();
        if (hit_full) ring_block_hit = 1'b1;
        // a closed block counts once if any of its bytes met a full fifo
        if (req.block_end) begin
          if (ring_block_hit) ring_blocks_lost++;
          ring_block_hit = 1'b0;
        end
      end
      MODE_READ: begin
        if (ring_fill != 0) begin
          res.read_byte  = ring_bytes[RING_PTR_W'(ring_rd)];
          res.read_valid = 1'b1;
          ring_rd        = (ring_rd + 1) % RING_DEPTH;
          ring_fill--;
          refresh_high_water();
        end else begin
          empty_reads++;
        end
      end
      MODE_FLUSH: begin
        // statistics and a pending block mark survive a flush
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;
        ring_high = 1'b0;
        flushes++;
      end
      default: ;
    endcase
    res.fill_level     = LEVEL_W'(ring_fill);
    res.high_water     = ring_high;
    res.peak_fill      = LEVEL_W'(ring_peak);
    res.overflow_total = ring_blocks_lost;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch in %s at result %0d: expected %0h, got %0h",
               what, results_seen, want, got);
  endtask

  task automatic compare_result(input brb_out_t want, input brb_out_t got);
    if (got.read_byte !== want.read_byte)
      report_mismatch("read_byte", 32'(want.read_byte), 32'(got.read_byte));
    if (got.read_valid !== want.read_valid)
      report_mismatch("read_valid", 32'(want.read_valid), 32'(got.read_valid));
    if (got.write_accepted !== want.write_accepted)
      report_mismatch("write_accepted", 32'(want.write_accepted),
                      32'(got.write_accepted));
    if (got.fill_level !== want.fill_level)
      report_mismatch("fill_level", 32'(want.fill_level), 32'(got.fill_level));
    if (got.high_water !== want.high_water)
      report_mismatch("high_water", 32'(want.high_water), 32'(got.high_water));
    if (got.peak_fill !== want.peak_fill)
      report_mismatch("peak_fill", 32'(want.peak_fill), 32'(got.peak_fill));
    if (got.overflow_total !== want.overflow_total)
      report_mismatch("overflow_total", want.overflow_total, got.overflow_total);
  endtask

  // -------------------------------------------------------------------------
  // request driver: predicts on acceptance, then offers the next request
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(ring_step(in_req_i));
        requests_taken++;
      end
      // a stalled request stays as it is
      if (!in_valid_i || !in_stall_o) begin
        if (queued_requests.size() != 0
            && !(queued_requests[0].hold && due_results.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= queued_requests[0].req;
          void'(queued_requests.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // result monitor with random back-pressure
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (due_results.size() == 0)
          report_mismatch("result count, nothing due, fill_level", 32'd0,
                          32'(out_res_o.fill_level));
        else
          compare_result(due_results.pop_front(), out_res_o);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // watchdog: ends the run when neither channel moves for too long
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no request or result moved for %0d cycles", quiet_cycles);
        $display("byte_ring_buffer_with_overflow_policy test failed");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  task automatic queue_request(input logic [1:0] mode, input logic [7:0] data,
                               input logic last, input bit hold = 1'b0);
    request_slot_t slot;
    slot.req.mode       = mode;
    slot.req.write_byte = data;
    slot.req.block_end  = last;
    slot.hold           = hold;
    queued_requests.push_back(slot);
  endtask

  // a run of writes; close marks the last byte as the end of the block
  task automatic queue_write_block(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++)
      queue_request(MODE_WRITE, 8'($urandom), close && (i == len - 1));
  endtask

  // well-formed blocks until the fifo is filled past the brim
  task automatic queue_fill(input int unsigned count);
    int unsigned left;
    int unsigned len;
    left = count;
    while (left != 0) begin
      len = $urandom_range(24, 1);
      if (len > left) len = left;
      queue_write_block(len, 1'b1);
      left -= len;
    end
  endtask

  // mixed traffic: write blocks (a few left open), read bursts, the odd
  // flush and some noise with random fields and the spare mode
  task automatic queue_mix(input int unsigned count, input int unsigned write_pct);
    int unsigned made;
    int unsigned len;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      len  = $urandom_range(24, 1);
      if (pick < write_pct) begin
        queue_write_block(len, $urandom_range(9) != 0);
      end else if (pick < 94) begin
        for (int unsigned i = 0; i < len; i++)
          queue_request(MODE_READ, 8'($urandom), 1'($urandom));
      end else if (pick < 97) begin
        len = 1;
        queue_request(MODE_FLUSH, 8'($urandom), 1'($urandom));
      end else begin
        len = $urandom_range(4, 1);
        for (int unsigned i = 0; i < len; i++)
          queue_request(2'($urandom), 8'($urandom), 1'($urandom));
      end
      made += len;
    end
  endtask

  // wait until every request has gone in and every result has come out
  task automatic wait_until_drained();
    while (queued_requests.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // two-phase register write, done only while the fifo is idle
  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_POLICY:    cfg_policy    = value[1:0];
      ADDR_HIGH_MARK: cfg_high_mark = 32'(value[LEVEL_W-1:0]);
      ADDR_LOW_MARK:  cfg_low_mark  = 32'(value[LEVEL_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] policy, input int unsigned high_mark,
                           input int unsigned low_mark);
    write_register(ADDR_POLICY, APB_DATA_W'(policy));
    write_register(ADDR_HIGH_MARK, APB_DATA_W'(high_mark));
    write_register(ADDR_LOW_MARK, APB_DATA_W'(low_mark));
  endtask

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------
  initial begin
    ring_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty read, spare mode, flush on empty, byte extremes,
    // reads down to empty, flush with data held
    queue_request(MODE_READ, 8'h00, 1'b0);
    queue_request(MODE_NOP, 8'hff, 1'b1);
    queue_request(MODE_FLUSH, 8'h00, 1'b0);
    queue_request(MODE_WRITE, 8'h00, 1'b0);
    queue_request(MODE_WRITE, 8'hff, 1'b1);
    queue_request(MODE_WRITE, 8'ha5, 1'b0);
    queue_request(MODE_NOP, 8'h00, 1'b0);
    queue_request(MODE_READ, 8'hff, 1'b1);
    queue_request(MODE_READ, 8'h00, 1'b0);
    queue_request(MODE_READ, 8'h00, 1'b0);
    queue_request(MODE_READ, 8'h00, 1'b0);
    queue_request(MODE_WRITE, 8'h5a, 1'b0);
    queue_request(MODE_WRITE, 8'h3c, 1'b1);
    queue_request(MODE_FLUSH, 8'hff, 1'b1);
    queue_request(MODE_READ, 8'h00, 1'b0);
    queue_request(MODE_WRITE, 8'h81, 1'b1);
    queue_request(MODE_READ, 8'h00, 1'b0);
    wait_until_drained();

    // drop oldest: fill past full, pause until drained, then churn near full
    configure(POLICY_DROP_OLDEST, 200, 50);
    queue_request(MODE_FLUSH, 8'h00, 1'b0);
    queue_fill(280);
    queue_request(MODE_READ, 8'h00, 1'b0, 1'b1);
    queue_mix(230, 52);
    wait_until_drained();

    // drop newest with the high mark at the top; swap the idling sides
    send_idle_pct  = 48;
    recv_stall_pct = 13;
    configure(POLICY_DROP_NEWEST, 256, 255);
    queue_request(MODE_FLUSH, 8'h00, 1'b0);
    queue_fill(270);
    queue_mix(250, 52);
    wait_until_drained();

    // error policy with marks crossed so clearing always wins; no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(POLICY_ERROR, 1, 256);
    queue_request(MODE_FLUSH, 8'h00, 1'b0);
    queue_fill(270);
    queue_mix(250, 52);
    wait_until_drained();

    // spare policy code starting from the fifo state left above
    configure(POLICY_SPARE, 128, 0);
    queue_mix(200, 45);
    wait_until_drained();
    repeat (12) @(posedge clk_i);

    $display("covered %0d requests and %0d results over four overflow settings",
             requests_taken, results_seen);
    $display("%0d bytes overwritten, %0d rejected, %0d empty reads, %0d flushes, %0d lost blocks",
             overwrites, rejects, empty_reads, flushes, ring_blocks_lost);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("byte_ring_buffer_with_overflow_policy test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               due_results.size());
      $display("byte_ring_buffer_with_overflow_policy test failed");
    end
    $finish;
  end

endmodule

### files.f
src/brb_pkg.sv
src/brb_cfg.sv
src/brb_store.sv
src/byte_ring_buffer_with_overflow_policy.sv
tb/tb_byte_ring_buffer_with_overflow_policy.sv
